### rtl/core/cps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// shared types and constants of the pneumatic cylinder supervisor
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int unsigned TIMEOUT_W  = 8;
	localparam int unsigned PRESCALE_W = 16;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 8'd5;
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd1000;

	// configuration register indexes
	localparam logic CFG_TIMEOUT  = 1'b0;
	localparam logic CFG_PRESCALE = 1'b1;

	typedef enum logic [2:0] {
		MODE_INIT       = 3'd0,
		MODE_RETRACTED  = 3'd1,
		MODE_EXTENDED   = 3'd2,
		MODE_EXTENDING  = 3'd3,
		MODE_RETRACTING = 3'd4
	} cps_mode_t;

	localparam logic [2:0] FAULT_NONE         = 3'd0;
	localparam logic [2:0] FAULT_RETRACT_LOST = 3'd1;
	localparam logic [2:0] FAULT_EXTEND_LOST  = 3'd2;
	localparam logic [2:0] FAULT_EXTEND_TIME  = 3'd3;
	localparam logic [2:0] FAULT_RETRACT_TIME = 3'd4;

	typedef struct packed {
		logic extend_cmd;
		logic sensor_extended;
		logic sensor_retracted;
	} cps_in_item_t;

	typedef struct packed {
		logic       valve_open;
		logic [2:0] position_state;
		logic [2:0] fault_code;
	} cps_out_item_t;

	// control from the state machine to the timer
	typedef struct packed {
		logic step;
		logic load;
	} cps_tmr_ctl_t;

endpackage
`default_nettype wire

### rtl/core/cps_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_timer
// tick prescaler and travel timeout down-counter
// ----------------------------------------------------------------------------
module cps_timer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cps_pkg::cps_tmr_ctl_t          ctl,
	input  wire logic [cps_pkg::TIMEOUT_W-1:0]  timeout_units,
	input  wire logic [cps_pkg::PRESCALE_W-1:0] prescale_reload,
	output logic                                timer_zero
);
	import cps_pkg::*;

	logic [PRESCALE_W-1:0] prescale_q;
	logic [TIMEOUT_W-1:0]  timer_q;

	assign timer_zero = (timer_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			timer_q    <= '0;
		end else if (ctl.step) begin
			if (prescale_q != '0) begin
				prescale_q <= prescale_q - PRESCALE_W'(1);
			end else begin
				prescale_q <= prescale_reload;
			end
			// a fresh load wins over a unit expiring in the same tick
			if (ctl.load) begin
				timer_q <= timeout_units;
			end else if (prescale_q == '0 && timer_q != '0) begin
				timer_q <= timer_q - TIMEOUT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/cps_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_fsm
// cylinder position state machine with valve drive and fault latch
// ----------------------------------------------------------------------------
module cps_fsm (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire cps_pkg::cps_in_item_t  item,
	input  wire logic                   timer_zero,
	output cps_pkg::cps_tmr_ctl_t       tmr_ctl,
	output cps_pkg::cps_out_item_t      result
);
	import cps_pkg::*;

	cps_mode_t  mode_q, mode_d;
	logic       valve_q, valve_d;
	logic [2:0] fault_q, fault_d;
	logic       load;

	// next state
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_RETRACTED: begin
				if (item.extend_cmd) mode_d = MODE_EXTENDING;
			end
			MODE_EXTENDED: begin
				if (!item.extend_cmd) mode_d = MODE_RETRACTING;
			end
			MODE_EXTENDING: begin
				if (item.sensor_extended) mode_d = MODE_EXTENDED;
			end
			MODE_RETRACTING: begin
				if (item.sensor_retracted) mode_d = MODE_RETRACTED;
			end
			default: begin
				// both sensors on counts as retracted
				if (item.sensor_retracted) mode_d = MODE_RETRACTED;
				else if (item.sensor_extended) mode_d = MODE_EXTENDED;
				else mode_d = MODE_INIT;
			end
		endcase
	end

	// valve, fault and timer load
	always_comb begin
		valve_d = valve_q;
		fault_d = fault_q;
		load    = 1'b0;
		unique case (mode_q)
			MODE_RETRACTED: begin
				if (!item.sensor_retracted) fault_d = FAULT_RETRACT_LOST;
				if (item.extend_cmd) begin
					valve_d = 1'b1;
					load    = 1'b1;
				end
			end
			MODE_EXTENDED: begin
				if (!item.sensor_extended) fault_d = FAULT_EXTEND_LOST;
				if (!item.extend_cmd) begin
					valve_d = 1'b0;
					load    = 1'b1;
				end
			end
			MODE_EXTENDING: begin
				if (!item.sensor_extended && timer_zero) fault_d = FAULT_EXTEND_TIME;
			end
			MODE_RETRACTING: begin
				if (!item.sensor_retracted && timer_zero) fault_d = FAULT_RETRACT_TIME;
			end
			default: begin
				valve_d = valve_q;
			end
		endcase
	end

	assign tmr_ctl.step = step;
	assign tmr_ctl.load = step & load;

	assign result.valve_open     = valve_d;
	assign result.position_state = mode_d;
	assign result.fault_code     = fault_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_INIT;
			valve_q <= 1'b0;
			fault_q <= FAULT_NONE;
		end else if (step) begin
			mode_q  <= mode_d;
			valve_q <= valve_d;
			fault_q <= fault_d;
		end
	end

	a_extending_valve_open: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_EXTENDING |-> valve_q)
		else $error("valve closed while extending");

	a_retracting_valve_closed: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_RETRACTING |-> !valve_q)
		else $error("valve open while retracting");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != FAULT_NONE |=> fault_q != FAULT_NONE)
		else $error("fault latch cleared without reset");

	a_move_loads_timer: assert property (@(posedge clk) disable iff (!arst_n)
		step && (mode_d == MODE_EXTENDING || mode_d == MODE_RETRACTING) && mode_d != mode_q
		|-> tmr_ctl.load)
		else $error("move started without timer load");

endmodule
`default_nettype wire

### rtl/core/pneumatic_cylinder_supervisor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pneumatic_cylinder_supervisor_top
// supervises one double-acting pneumatic cylinder, one item per tick
// ----------------------------------------------------------------------------
// an accepted item passes the input register and then the result register
// throughput: one item per cycle while out_stall is low, set by the input
//   register feeding the result register through the state machine and timer
//   logic; a result held by out_stall stops the state machine, and the input
//   register takes one more item if it is empty and then raises in_stall
// reset: asynchronous active low; cylinder in init, valve closed, no fault,
//   timeout 5 units, prescale reload 1000
// ----------------------------------------------------------------------------
module pneumatic_cylinder_supervisor_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire cps_pkg::cps_in_item_t          in_data,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output cps_pkg::cps_out_item_t              out_data,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [cps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cps_pkg::*;

	// configuration registers
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [PRESCALE_W-1:0] prescale_q;

	// input stage
	logic         valid_s1;
	cps_in_item_t item_s1;

	// result register
	logic          out_valid_q;
	cps_out_item_t out_item_q;

	logic          advance;
	logic          in_take;
	logic          timer_zero;
	cps_tmr_ctl_t  tmr_ctl;
	cps_out_item_t result;

	// the held item moves on whenever the result register is free or emptying
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			prescale_q <= PRESCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT:  timeout_q  <= cfg_data[TIMEOUT_W-1:0];
				CFG_PRESCALE: prescale_q <= cfg_data[PRESCALE_W-1:0];
				default:      timeout_q  <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_item_q <= result;
	end

	// state machine steps once per item as it leaves the input stage
	cps_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.timer_zero (timer_zero),
		.tmr_ctl    (tmr_ctl),
		.result     (result)
	);

	// prescaler and travel timeout, using the value held at the start of the tick
	cps_timer u_timer (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (tmr_ctl),
		.timeout_units   (timeout_q),
		.prescale_reload (prescale_q),
		.timer_zero      (timer_zero)
	);

endmodule
`default_nettype wire
